// ----- hdl/bfft_pkg.sv -----
// Package of shared types and codes for the best-fit free block table.
package bfft_pkg;

	localparam logic [1:0] OP_RELEASE = 2'd0;
	localparam logic [1:0] OP_PLACE   = 2'd1;
	localparam logic [1:0] OP_SET_END = 2'd2;

	// Search or release token that walks the row of table cells.
	typedef struct packed {
		logic        active;
		logic        is_place;
		logic        taken;
		logic [15:0] size;
		logic [31:0] offset;
		logic [15:0] best_size;
		logic [31:0] best_offset;
	} pkt_t;

endpackage

// ----- hdl/bfft_in_if.sv -----
// Interface of the request channel: valid, ready and the request payload.
interface bfft_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] block_offset;
	logic [15:0] item_size;

	modport source (output valid, output op, output block_offset, output item_size,
		input ready);
	modport sink (input valid, input op, input block_offset, input item_size,
		output ready);
endinterface

// ----- hdl/bfft_out_if.sv -----
// Interface of the result channel: valid, ready and the result payload.
interface bfft_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] placed_offset;
	logic [15:0] space_size;
	logic [15:0] slack;
	logic        reused;
	logic        status;

	modport source (output valid, output placed_offset, output space_size, output slack,
		output reused, output status, input ready);
	modport sink (input valid, input placed_offset, input space_size, input slack,
		input reused, input status, output ready);
endinterface

// ----- hdl/bfft_cell.sv -----
// One table cell: holds a free block entry and updates the token passing through.
module bfft_cell #(
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfft_pkg::pkt_t     pkt_in,
	input  logic [IDX_W-1:0]   idx_in,
	output bfft_pkg::pkt_t     pkt_out,
	output logic [IDX_W-1:0]   idx_out,
	input  logic               clr_en,
	input  logic [IDX_W-1:0]   clr_idx
);
	import bfft_pkg::*;

	logic        valid_q;
	logic [31:0] off_q;
	logic [15:0] size_q;
	pkt_t        pkt_q;
	logic [IDX_W-1:0] idx_q;
	logic        claim;
	logic        hit;
	logic        clr_me;
	pkt_t        pkt_nxt;
	logic [IDX_W-1:0] idx_nxt;

	assign claim = pkt_in.active && !pkt_in.is_place && !pkt_in.taken && !valid_q;
	assign hit   = pkt_in.active && pkt_in.is_place && valid_q && (size_q >= pkt_in.size)
		&& (!pkt_in.taken || (size_q < pkt_in.best_size));
	assign clr_me = clr_en && (clr_idx == IDX_W'(INDEX));

	always_comb begin
		pkt_nxt = pkt_in;
		idx_nxt = idx_in;
		if (claim) begin
			pkt_nxt.taken = 1'b1;
		end
		if (hit) begin
			pkt_nxt.taken       = 1'b1;
			pkt_nxt.best_size   = size_q;
			pkt_nxt.best_offset = off_q;
			idx_nxt             = IDX_W'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (clr_me) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			off_q  <= pkt_in.offset;
			size_q <= pkt_in.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q.active <= 1'b0;
		end else begin
			pkt_q <= pkt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_nxt;
	end

	assign pkt_out = pkt_q;
	assign idx_out = idx_q;
endmodule

// ----- hdl/best_fit_free_block_table_unit.sv -----
// Top level of the best-fit free block table: request handling, cell row and result register.
module best_fit_free_block_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	bfft_in_if.sink    req,
	bfft_out_if.source rsp
);
	// The table sits in a row of TABLE_DEPTH cells, one entry per cell. A release or
	// place request launches a token that steps through the row one cell per clock:
	// a release is stored by the first empty cell it meets, and a place token keeps the
	// smallest fitting entry seen so far, so the earliest slot wins a tie. Because the
	// token walks the whole row, the result beat of a release or place request is offered
	// only after the token has left the last cell and its result has passed the pending
	// result registers into the output register. Setting the end pointer, and the unused
	// op code, launch no token and go straight to the pending result and output registers.
	// One request is in progress at a time. The result sits in an output register, so the
	// next request beat is accepted while an earlier result beat still waits to be taken.
	// A placed entry is freed in the cycle its result enters the output register; a
	// record that fits nowhere is appended at the end pointer, which then advances by
	// the request size and wraps at 2^32. There is no clearing pass after reset.
	import bfft_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] end_ptr_q;
	pkt_t        inj_q;

	pkt_t             pkt_chain [0:TABLE_DEPTH];
	logic [IDX_W-1:0] idx_chain [0:TABLE_DEPTH];

	// Result waiting to go to the output register, plus the side effects it carries.
	logic [31:0]      pend_off_q;
	logic [15:0]      pend_space_q;
	logic [15:0]      pend_slack_q;
	logic             pend_reused_q;
	logic             pend_status_q;
	logic             pend_clr_q;
	logic             pend_adv_q;
	logic [IDX_W-1:0] pend_idx_q;

	logic        out_valid_q;
	logic [31:0] out_off_q;
	logic [15:0] out_space_q;
	logic [15:0] out_slack_q;
	logic        out_reused_q;
	logic        out_status_q;

	logic   accept;
	logic   load_out;
	pkt_t   tail;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign tail      = pkt_chain[TABLE_DEPTH];

	assign pkt_chain[0] = inj_q;
	assign idx_chain[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bfft_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pkt_in  (pkt_chain[i]),
			.idx_in  (idx_chain[i]),
			.pkt_out (pkt_chain[i+1]),
			.idx_out (idx_chain[i+1]),
			.clr_en  (load_out && pend_clr_q),
			.clr_idx (pend_idx_q)
		);
	end

	// Token launch: only a release or place beat starts a walk along the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q.active <= 1'b0;
		end else begin
			inj_q.active      <= accept && (req.op inside {OP_RELEASE, OP_PLACE});
			inj_q.is_place    <= (req.op == OP_PLACE);
			inj_q.taken       <= 1'b0;
			inj_q.size        <= req.item_size;
			inj_q.offset      <= req.block_offset;
			inj_q.best_size   <= '0;
			inj_q.best_offset <= '0;
		end
	end

	// Sequencer and end pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_ptr_q  <= '0;
			pend_clr_q <= 1'b0;
			pend_adv_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.op inside {OP_RELEASE, OP_PLACE}) begin
							state_q <= ST_SCAN;
						end else begin
							if (req.op == OP_SET_END) begin
								end_ptr_q <= req.block_offset;
							end
							pend_clr_q <= 1'b0;
							pend_adv_q <= 1'b0;
							state_q    <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (tail.active) begin
						pend_clr_q <= tail.is_place && tail.taken;
						pend_adv_q <= tail.is_place && !tail.taken;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						if (pend_adv_q) begin
							end_ptr_q <= end_ptr_q + 32'(pend_space_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields, cleared when a request is accepted and formed when the token leaves the last cell.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept) begin
			pend_off_q    <= '0;
			pend_space_q  <= '0;
			pend_slack_q  <= '0;
			pend_reused_q <= 1'b0;
			pend_status_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && tail.active) begin
			pend_idx_q <= idx_chain[TABLE_DEPTH];
			if (!tail.is_place) begin
				pend_off_q    <= '0;
				pend_space_q  <= '0;
				pend_slack_q  <= '0;
				pend_reused_q <= 1'b0;
				pend_status_q <= !tail.taken;
			end else if (tail.taken) begin
				pend_off_q    <= tail.best_offset;
				pend_space_q  <= tail.best_size;
				pend_slack_q  <= tail.best_size - tail.size;
				pend_reused_q <= 1'b1;
				pend_status_q <= 1'b0;
			end else begin
				pend_off_q    <= end_ptr_q;
				pend_space_q  <= tail.size;
				pend_slack_q  <= '0;
				pend_reused_q <= 1'b0;
				pend_status_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_off_q    <= pend_off_q;
			out_space_q  <= pend_space_q;
			out_slack_q  <= pend_slack_q;
			out_reused_q <= pend_reused_q;
			out_status_q <= pend_status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.placed_offset = out_off_q;
	assign rsp.space_size    = out_space_q;
	assign rsp.slack         = out_slack_q;
	assign rsp.reused        = out_reused_q;
	assign rsp.status        = out_status_q;
endmodule

// ----- hdl/bfft_checker.sv -----
// Port-level checks for the best-fit free block table, bound to the top level.
module bfft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] placed_offset,
	input logic [15:0] space_size,
	input logic [15:0] slack,
	input logic        reused,
	input logic        status
);
	// A stalled result beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(placed_offset)
			&& $stable(space_size) && $stable(slack) && $stable(reused) && $stable(status))
		else $error("stalled result beat changed");

	// Only one request is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	// A full-table report never comes with placement fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !reused && (placed_offset == 32'd0)
			&& (space_size == 16'd0) && (slack == 16'd0))
		else $error("full status mixed with placement fields");

	// The slack of a reused block never exceeds the block itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reused |-> (slack <= space_size))
		else $error("slack larger than reused block");
endmodule

bind best_fit_free_block_table_unit bfft_checker u_bfft_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.placed_offset (rsp.placed_offset),
	.space_size    (rsp.space_size),
	.slack         (rsp.slack),
	.reused        (rsp.reused),
	.status        (rsp.status)
);
